// ----- hdl/wfpd_pkg.sv -----
// shared types, constants and helpers for the wall following pd drive
`timescale 1ns / 1ps
package wfpd_pkg;

  // saturated distance, unsigned q15.8 maximum
  localparam logic [22:0] QMAX = 23'h7FFFFF;
  localparam logic [20:0] SIDE_NUM = 21'd156383;
  localparam logic [20:0] SIDE_OFF = 21'd116;
  localparam logic [20:0] FRONT_NUM = 21'd1334565;
  localparam logic [20:0] FRONT_OFF = 21'd1450;
  localparam logic [23:0] MEAN_OFFSET = 24'd2304;

  // serial divider and multiplier sizes
  localparam int SNS_NW = 21;
  localparam int SNS_DW = 8;
  localparam int DER_NW = 55;
  localparam int DER_DW = 32;
  localparam int MUL_AW = 31;
  localparam int MUL_BW = 24;

  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 31;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BASE_SPEED      = 3'd0,
    REG_GAIN            = 3'd1,
    REG_DERIVATIVE_TIME = 3'd2,
    REG_TARGET_DISTANCE = 3'd3,
    REG_FRONT_LIMIT     = 3'd4,
    REG_WALL_WINDOW     = 3'd5,
    REG_SQUARE_DEADBAND = 3'd6,
    REG_CORRECTION_PWM  = 3'd7
  } cfg_reg_e;

  typedef enum logic [2:0] {
    ACT_STOP         = 3'd0,
    ACT_PD_DRIVE     = 3'd1,
    ACT_ROTATE_RIGHT = 3'd2,
    ACT_ROTATE_LEFT  = 3'd3,
    ACT_OBSTACLE     = 3'd4,
    ACT_WALL_LOST    = 3'd5
  } action_e;

  typedef struct packed {
    logic [7:0]  right_front_raw;
    logic [7:0]  right_back_raw;
    logic [7:0]  front_raw;
    logic [31:0] elapsed_cycles;
  } in_t;

  typedef struct packed {
    logic [2:0] action;
    logic [7:0] left_pwm;
    logic [7:0] right_pwm;
    logic       left_forward;
    logic       right_forward;
  } out_t;

  // handshake between sequencer and a serial unit
  typedef struct packed {
    logic start;
    logic done;
  } unit_ctl_t;

  // clamp a signed q56.8 duty to 0..255 whole steps
  function automatic logic [7:0] clamp_pwm(input logic signed [63:0] v);
    logic [7:0] r;
    if (v < 64'sd0) begin
      r = 8'd0;
    end else if (v > 64'sd65280) begin
      r = 8'd255;
    end else begin
      r = v[15:8];
    end
    return r;
  endfunction

endpackage

// ----- hdl/wfpd_sdiv.sv -----
// bit-serial restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps
module wfpd_sdiv #(
  parameter int NW = wfpd_pkg::SNS_NW,
  parameter int DW = wfpd_pkg::SNS_DW
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [NW-1:0] num_i,
  input  logic [DW-1:0] den_i,
  output logic          done_o,
  output logic [NW-1:0] quot_o
);

  localparam int CW = $clog2(NW + 1);

  logic [DW-1:0] rem_q, den_q;
  logic [NW-1:0] quo_q;
  logic [CW-1:0] cnt_q;
  logic          run_q, done_q;
  logic [DW:0]   trial;
  logic          ge;

  // shift in the next numerator bit and try a subtract
  assign trial = {rem_q, quo_q[NW-1]};
  assign ge    = trial >= {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= CW'(NW);
      end else if (run_q) begin
        cnt_q <= cnt_q - CW'(1);
        if (cnt_q == CW'(1)) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= num_i;
      den_q <= den_i;
    end else if (run_q) begin
      rem_q <= ge ? DW'(trial - {1'b0, den_q}) : trial[DW-1:0];
      quo_q <= {quo_q[NW-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign quot_o = quo_q;

endmodule

// ----- hdl/wfpd_smul.sv -----
// bit-serial shift-add multiplier, one multiplier bit per cycle
`timescale 1ns / 1ps
module wfpd_smul #(
  parameter int AW = wfpd_pkg::MUL_AW,
  parameter int BW = wfpd_pkg::MUL_BW
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [AW-1:0]    a_i,
  input  logic [BW-1:0]    b_i,
  output logic             done_o,
  output logic [AW+BW-1:0] prod_o
);

  localparam int CW = $clog2(BW + 1);

  logic [AW-1:0]    a_q;
  logic [AW+BW-1:0] p_q;
  logic [CW-1:0]    cnt_q;
  logic             run_q, done_q;
  logic [AW:0]      sum;

  // add the multiplicand when the low bit is set
  assign sum = {1'b0, p_q[AW+BW-1:BW]} + (p_q[0] ? {1'b0, a_q} : '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= CW'(BW);
      end else if (run_q) begin
        cnt_q <= cnt_q - CW'(1);
        if (cnt_q == CW'(1)) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // partial product shifts right each step
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q <= a_i;
      p_q <= {{AW{1'b0}}, b_i};
    end else if (run_q) begin
      p_q <= {sum, p_q[BW-1:1]};
    end
  end

  assign done_o = done_q;
  assign prod_o = p_q;

endmodule

// ----- hdl/wall_follow_pd_drive.sv -----
// wall following pd drive: sequencer, config registers and result register
// each item: three sensor conversions in turn (a divide, or a direct saturate for a raw
// zero), then decide and load; pd adds the gain and clamp states, and with nonzero elapsed
// time a multiply and then a divide before them
// one item at a time: a new item is taken only in idle, entered when the result is loaded
// reset: registers to defaults, previous mean 0, first sample pending, no tracking
`timescale 1ns / 1ps
module wall_follow_pd_drive (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  wfpd_pkg::in_t                        in_data_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output wfpd_pkg::out_t                       out_data_o,
  input  logic                                 cfg_we_i,
  input  logic [wfpd_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [wfpd_pkg::CFG_DATA_W-1:0]      cfg_wdata_i
);

  typedef enum logic [3:0] {
    ST_IDLE, ST_CONV, ST_CWAIT, ST_DECIDE, ST_MUL, ST_DDIV, ST_GAIN, ST_CLAMP, ST_FIN
  } state_e;

  localparam int SNW = wfpd_pkg::SNS_NW;
  localparam int DNW = wfpd_pkg::DER_NW;
  localparam int MAW = wfpd_pkg::MUL_AW;
  localparam int MBW = wfpd_pkg::MUL_BW;

  state_e state_q;

  // configuration
  logic [7:0]  base_q, target_q, flimit_q, window_q, dband_q, corr_q;
  logic [3:0]  gain_q;
  logic [30:0] td_q;

  // item and control state
  wfpd_pkg::in_t item_q;
  logic [1:0]    k_q;
  logic [22:0]   s1_q, s2_q, f_q, prev_q, mean_q;
  logic          first_q, track_q, neg_q;
  logic signed [55:0] der_q;
  logic signed [61:0] u_q;
  logic [2:0]    act_q;
  logic [7:0]    lp_q, rp_q;
  logic          lf_q, rf_q;
  wfpd_pkg::out_t out_q;
  logic          out_valid_q;
  logic          fin_load;

  // sensor divider
  wfpd_pkg::unit_ctl_t sdiv_ctl, mul_ctl, ddiv_ctl;
  logic [7:0]     raw;
  logic [SNW-1:0] snum, squot, sval;
  logic [MAW+MBW-1:0] prod;
  logic [DNW-1:0]     dquot;

  always_comb begin
    case (k_q)
      2'd0:    raw = item_q.right_front_raw;
      2'd1:    raw = item_q.right_back_raw;
      default: raw = item_q.front_raw;
    endcase
  end

  // rounded reciprocal: (num + raw/2) / raw
  assign snum = ((k_q == 2'd2) ? wfpd_pkg::FRONT_NUM : wfpd_pkg::SIDE_NUM)
                + SNW'(raw >> 1);
  assign sval = squot - ((k_q == 2'd2) ? wfpd_pkg::FRONT_OFF : wfpd_pkg::SIDE_OFF);
  assign sdiv_ctl.start = (state_q == ST_CONV) && (raw != 8'd0);

  wfpd_sdiv #(.NW(SNW), .DW(wfpd_pkg::SNS_DW)) u_sdiv (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(sdiv_ctl.start),
    .num_i  (snum),
    .den_i  (raw),
    .done_o (sdiv_ctl.done),
    .quot_o (squot)
  );

  // decision terms
  logic [23:0] ssum, mraw;
  logic [22:0] mean;
  logic signed [24:0] diff, ndiff, mag, win, dbw;
  logic signed [23:0] delta;
  logic [23:0]   dmag;
  logic          wall, obst, pd;

  assign ssum  = {1'b0, s1_q} + {1'b0, s2_q};
  assign mraw  = {1'b0, ssum[23:1]} + wfpd_pkg::MEAN_OFFSET;
  assign mean  = (mraw > {1'b0, wfpd_pkg::QMAX}) ? wfpd_pkg::QMAX : mraw[22:0];
  assign diff  = $signed({2'b0, s1_q}) - $signed({2'b0, s2_q});
  assign ndiff = -diff;
  assign mag   = diff[24] ? ndiff : diff;
  assign win   = $signed({9'b0, window_q, 8'b0});
  assign dbw   = $signed({9'b0, dband_q, 8'b0});
  assign obst  = f_q < {7'b0, flimit_q, 8'b0};
  assign wall  = (diff < win) && (ndiff < win);
  assign pd    = !first_q && !obst && wall && !(mag > dbw);
  assign delta = $signed({1'b0, prev_q}) - $signed({1'b0, mean});
  assign dmag  = delta[23] ? 24'(-delta) : 24'(delta);

  assign mul_ctl.start = (state_q == ST_DECIDE) && pd && (item_q.elapsed_cycles != 32'd0);

  wfpd_smul #(.AW(MAW), .BW(MBW)) u_smul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(mul_ctl.start),
    .a_i    (td_q),
    .b_i    (dmag),
    .done_o (mul_ctl.done),
    .prod_o (prod)
  );

  assign ddiv_ctl.start = (state_q == ST_MUL) && mul_ctl.done;

  wfpd_sdiv #(.NW(DNW), .DW(wfpd_pkg::DER_DW)) u_ddiv (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(ddiv_ctl.start),
    .num_i  (prod),
    .den_i  (item_q.elapsed_cycles),
    .done_o (ddiv_ctl.done),
    .quot_o (dquot)
  );

  // pd arithmetic
  logic signed [24:0] err;
  logic signed [56:0] esum;
  logic signed [61:0] sext, u_d;
  logic signed [63:0] vbase, vr, vl;

  assign err   = $signed({9'b0, target_q, 8'b0}) - $signed({2'b0, mean_q});
  assign esum  = 57'(err) + 57'(der_q);
  assign sext  = 62'(esum);
  // gain is four bits: shift and add
  assign u_d   = (gain_q[0] ? sext : 62'sd0)
               + (gain_q[1] ? (sext <<< 1) : 62'sd0)
               + (gain_q[2] ? (sext <<< 2) : 62'sd0)
               + (gain_q[3] ? (sext <<< 3) : 62'sd0);
  assign vbase = $signed({48'b0, base_q, 8'b0});
  assign vr    = vbase + 64'(u_q);
  assign vl    = vbase - 64'(u_q);

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q   <= 8'd50;
      gain_q   <= 4'd3;
      td_q     <= 31'd128000000;
      target_q <= 8'd18;
      flimit_q <= 8'd50;
      window_q <= 8'd20;
      dband_q  <= 8'd3;
      corr_q   <= 8'd70;
    end else if (cfg_we_i) begin
      case (wfpd_pkg::cfg_reg_e'(cfg_idx_i))
        wfpd_pkg::REG_BASE_SPEED:      base_q   <= cfg_wdata_i[7:0];
        wfpd_pkg::REG_GAIN:            gain_q   <= cfg_wdata_i[3:0];
        wfpd_pkg::REG_DERIVATIVE_TIME: td_q     <= cfg_wdata_i[30:0];
        wfpd_pkg::REG_TARGET_DISTANCE: target_q <= cfg_wdata_i[7:0];
        wfpd_pkg::REG_FRONT_LIMIT:     flimit_q <= cfg_wdata_i[7:0];
        wfpd_pkg::REG_WALL_WINDOW:     window_q <= cfg_wdata_i[7:0];
        wfpd_pkg::REG_SQUARE_DEADBAND: dband_q  <= cfg_wdata_i[7:0];
        wfpd_pkg::REG_CORRECTION_PWM:  corr_q   <= cfg_wdata_i[7:0];
        default: ;
      endcase
    end
  end

  // result register takes a new item when empty or being drained
  assign fin_load = (state_q == ST_FIN) && (!out_valid_q || out_ready_i);

  // sequencer, state and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      first_q     <= 1'b1;
      track_q     <= 1'b0;
      prev_q      <= '0;
      out_valid_q <= 1'b0;
      k_q         <= '0;
    end else begin
      if (fin_load) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            item_q  <= in_data_i;
            k_q     <= 2'd0;
            state_q <= ST_CONV;
          end
        end
        ST_CONV: begin
          if (raw == 8'd0) begin
            case (k_q)
              2'd0:    s1_q <= wfpd_pkg::QMAX;
              2'd1:    s2_q <= wfpd_pkg::QMAX;
              default: f_q  <= wfpd_pkg::QMAX;
            endcase
            if (k_q == 2'd2) begin
              state_q <= ST_DECIDE;
            end else begin
              k_q <= k_q + 2'd1;
            end
          end else begin
            state_q <= ST_CWAIT;
          end
        end
        ST_CWAIT: begin
          if (sdiv_ctl.done) begin
            case (k_q)
              2'd0:    s1_q <= 23'(sval);
              2'd1:    s2_q <= 23'(sval);
              default: f_q  <= 23'(sval);
            endcase
            if (k_q == 2'd2) begin
              state_q <= ST_DECIDE;
            end else begin
              k_q     <= k_q + 2'd1;
              state_q <= ST_CONV;
            end
          end
        end
        ST_DECIDE: begin
          mean_q <= mean;
          prev_q <= mean;
          neg_q  <= delta[23];
          der_q  <= '0;
          act_q  <= wfpd_pkg::ACT_STOP;
          lp_q   <= 8'd0;
          rp_q   <= 8'd0;
          lf_q   <= 1'b0;
          rf_q   <= 1'b0;
          state_q <= ST_FIN;
          if (first_q) begin
            first_q <= 1'b0;
          end else if (obst) begin
            act_q <= wfpd_pkg::ACT_OBSTACLE;
          end else if (wall) begin
            if (mag > dbw) begin
              lp_q <= corr_q;
              rp_q <= corr_q;
              if (diff > 25'sd0) begin
                act_q <= wfpd_pkg::ACT_ROTATE_RIGHT;
                lf_q  <= 1'b1;
              end else begin
                act_q <= wfpd_pkg::ACT_ROTATE_LEFT;
                rf_q  <= 1'b1;
              end
            end else begin
              track_q <= 1'b1;
              state_q <= (item_q.elapsed_cycles != 32'd0) ? ST_MUL : ST_GAIN;
            end
          end else if (track_q) begin
            track_q <= 1'b0;
            act_q   <= wfpd_pkg::ACT_WALL_LOST;
          end
        end
        ST_MUL: begin
          if (mul_ctl.done) begin
            state_q <= ST_DDIV;
          end
        end
        ST_DDIV: begin
          if (ddiv_ctl.done) begin
            der_q   <= neg_q ? -$signed({1'b0, dquot}) : $signed({1'b0, dquot});
            state_q <= ST_GAIN;
          end
        end
        ST_GAIN: begin
          u_q     <= u_d;
          state_q <= ST_CLAMP;
        end
        ST_CLAMP: begin
          act_q   <= wfpd_pkg::ACT_PD_DRIVE;
          rp_q    <= wfpd_pkg::clamp_pwm(vr);
          lp_q    <= wfpd_pkg::clamp_pwm(vl);
          lf_q    <= 1'b1;
          rf_q    <= 1'b1;
          state_q <= ST_FIN;
        end
        ST_FIN: begin
          if (fin_load) begin
            out_q.action        <= act_q;
            out_q.left_pwm      <= lp_q;
            out_q.right_pwm     <= rp_q;
            out_q.left_forward  <= lf_q;
            out_q.right_forward <= rf_q;
            state_q             <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
